/* rtl/spiadc_pkg.sv */
// Shared types and constants for the serial converter read block.
// No dependencies; imported by spiadc_core and spi_adc_sample_reader.
`default_nettype none
package spiadc_pkg;

  localparam int COMMAND_BITS = 5;
  localparam int READ_CLOCKS  = 13;
  localparam int TOTAL_PULSES = COMMAND_BITS + READ_CLOCKS;
  localparam int LAST_PHASE   = 2 * TOTAL_PULSES - 1;

  localparam int PHASE_W  = 6;
  localparam int PULSE_W  = PHASE_W - 1;
  localparam int CMD_W    = 8;
  localparam int DATA_W   = 13;
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 12;

  localparam logic [CMD_W-1:0] CMD_HEADER = 8'h18;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAN_W-1:0] channel;
    logic              miso_level;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                error;
    logic                done_res;
    logic                busy_res;
    logic                mosi_level;
    logic                sclk_level;
    logic                cs_level;
  } result_t;

endpackage
`default_nettype wire

/* rtl/spi_adc_sample_reader.sv */
// Top level of the serial converter read block: stream ports, input and result registers.
// Depends on spiadc_pkg and spiadc_core.
`default_nettype none
// Drives chip select, serial clock and command data of a 12-bit serial converter and
// collects its sample. An idle start transaction (tuser = 0) carrying a channel no higher
// than max_channel lowers chip select and loads the five-bit command; every tick
// transaction (tuser = 1) then advances one clock phase, 36 ticks in all, and the
// last one returns the sample with done and raises chip select. A channel above the
// limit is rejected at once with done and error. Every input transaction yields
// exactly one result carrying the pin levels after it. One transaction is taken per
// clock cycle while the result port is not stalled: the sequencer update is a single
// short step between the input register and the result register, and the result
// register takes a new result in the same cycle as the waiting one is taken.
module spi_adc_sample_reader
  import spiadc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [2:0] channel, [3] miso_level, [7:4] zero
  input  wire logic        s_axis_tuser,  // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [0] cs_level, [1] sclk_level, [2] mosi_level,
                                          // [3] busy_res, [4] done_res, [5] error,
                                          // [17:6] sample_value, [23:18] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data       // [2:0] max_channel, [7:3] ignored
);

  logic              in_valid;
  item_t             in_item;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic              out_adv;
  logic              step;
  logic [CHAN_W-1:0] max_channel;

  assign out_adv       = !out_valid || m_axis_tready;
  assign step          = in_valid && out_adv;
  assign s_axis_tready = !in_valid || out_adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channel <= CHAN_W'(4);
    end else if (cfg_valid) begin
      max_channel <= cfg_data[CHAN_W-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.kind       <= kind_t'(s_axis_tuser);
      in_item.channel    <= s_axis_tdata[CHAN_W-1:0];
      in_item.miso_level <= s_axis_tdata[CHAN_W];
    end
  end

  spiadc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_item),
    .max_channel (max_channel),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res};

endmodule
`default_nettype wire

/* rtl/spiadc_core.sv */
// Sequencer state and per-transaction update for the converter read.
// Depends on spiadc_pkg.
`default_nettype none
module spiadc_core
  import spiadc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire item_t             item,
  input  wire logic [CHAN_W-1:0] max_channel,
  output result_t                res
);

  logic [PHASE_W-1:0] phase_count, phase_count_next;
  logic [CMD_W-1:0]   command_shift, command_shift_next;
  logic [DATA_W-1:0]  data_shift, data_shift_next;
  logic               select_reg, select_reg_next;
  logic               clock_reg, clock_reg_next;
  logic               command_out_reg, command_out_reg_next;

  logic [PHASE_W-1:0] p;
  logic [PULSE_W-1:0] pulse;
  logic               busy, done, err;
  logic [SAMPLE_W-1:0] sample;

  assign p     = phase_count - PHASE_W'(1);
  assign pulse = p[PHASE_W-1:1];

  always_comb begin
    phase_count_next     = phase_count;
    command_shift_next   = command_shift;
    data_shift_next      = data_shift;
    select_reg_next      = select_reg;
    clock_reg_next       = clock_reg;
    command_out_reg_next = command_out_reg;
    busy   = 1'b0;
    done   = 1'b0;
    err    = 1'b0;
    sample = '0;
    if (item.kind == KIND_START) begin
      if (phase_count != '0) begin
        busy = 1'b1;
      end else if (item.channel > max_channel) begin
        done = 1'b1;
        err  = 1'b1;
      end else begin
        select_reg_next      = 1'b0;
        clock_reg_next       = 1'b0;
        command_shift_next   = {CMD_HEADER[CMD_W-4:0] | {2'b00, item.channel}, 3'b000};
        command_out_reg_next = command_shift_next[CMD_W-1];
        data_shift_next      = '0;
        phase_count_next     = PHASE_W'(1);
        busy                 = 1'b1;
      end
    end else if (phase_count != '0) begin
      if (!p[0]) begin
        // rising edge
        clock_reg_next   = 1'b1;
        phase_count_next = phase_count + PHASE_W'(1);
        busy             = 1'b1;
      end else begin
        clock_reg_next = 1'b0;
        if (pulse < PULSE_W'(COMMAND_BITS)) begin
          command_shift_next = {command_shift[CMD_W-2:0], 1'b0};
          if (pulse + PULSE_W'(1) < PULSE_W'(COMMAND_BITS)) begin
            command_out_reg_next = command_shift_next[CMD_W-1];
          end
        end else begin
          // first read pulse carries the null bit: shift in zero
          data_shift_next = {data_shift[DATA_W-2:0],
                             (pulse != PULSE_W'(COMMAND_BITS)) & item.miso_level};
        end
        if (p >= PHASE_W'(LAST_PHASE)) begin
          select_reg_next  = 1'b1;
          phase_count_next = '0;
          done             = 1'b1;
          sample           = data_shift_next[SAMPLE_W-1:0];
        end else begin
          phase_count_next = phase_count + PHASE_W'(1);
          busy             = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.cs_level     = select_reg_next;
    res.sclk_level   = clock_reg_next;
    res.mosi_level   = command_out_reg_next;
    res.busy_res     = busy;
    res.done_res     = done;
    res.error        = err;
    res.sample_value = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count     <= '0;
      command_shift   <= '0;
      data_shift      <= '0;
      select_reg      <= 1'b1;
      clock_reg       <= 1'b0;
      command_out_reg <= 1'b0;
    end else if (step) begin
      phase_count     <= phase_count_next;
      command_shift   <= command_shift_next;
      data_shift      <= data_shift_next;
      select_reg      <= select_reg_next;
      clock_reg       <= clock_reg_next;
      command_out_reg <= command_out_reg_next;
    end
  end

  a_idle_deselected: assert property (@(posedge clk) disable iff (rst)
    phase_count == '0 |-> select_reg && !clock_reg)
    else $error("chip select or clock active while idle");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_count <= PHASE_W'(LAST_PHASE + 1))
    else $error("phase count beyond end of sequence");

  a_tick_toggles: assert property (@(posedge clk) disable iff (rst)
    step && item.kind == KIND_TICK && phase_count != '0 |=> clock_reg != $past(clock_reg))
    else $error("tick while busy did not toggle the serial clock");

  a_done_excl_busy: assert property (@(posedge clk) disable iff (rst)
    step |-> !(res.done_res && res.busy_res))
    else $error("done and busy reported together");

endmodule
`default_nettype wire
